// File: sv/serial_command_line_parser_macros.svh
// Assertion macros shared by the command parser RTL.
// No dependencies; files take it in with an include.
`ifndef SERIAL_COMMAND_LINE_PARSER_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_MACROS_SVH

// cond must hold on every edge out of reset
`define SCP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scp assertion failed");

// cons must hold on the same edge as ante
`define SCP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scp assertion failed");

// cons must hold on the edge after ante
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scp assertion failed");

`endif

// File: sv/scp_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the serial command line parser.
// No dependencies.
package scp_pkg;

  localparam int PRESSURE_W = 11;
  localparam int HEAD_LEN   = 7;   // positions 0..6 are all a command can look at
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [7:0] END_MARK   = 8'd59;   // ';'
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [23:0] WORD_SET = {8'd115, 8'd101, 8'd116};  // "set"
  localparam logic [23:0] WORD_STP = {8'd115, 8'd116, 8'd112};  // "stp"
  localparam logic [23:0] WORD_RUN = {8'd114, 8'd117, 8'd110};  // "run"
  localparam logic [23:0] WORD_NOW = {8'd110, 8'd111, 8'd119};  // "now"

  typedef enum logic [2:0] {
    REPLY_SET  = 3'd0,
    REPLY_STOP = 3'd1,
    REPLY_RUN  = 3'd2,
    REPLY_NOW  = 3'd3,
    REPLY_BAD  = 3'd4
  } reply_t;

  // one decoded command line, handed from front to back
  typedef struct packed {
    reply_t                        reply;
    logic signed [PRESSURE_W-1:0]  value;
    logic signed [PRESSURE_W-1:0]  pressure;
  } cmd_t;

endpackage

// File: sv/scp_front.sv
`timescale 1ns / 1ps
// Front end: collects line characters and decodes a finished line into a cmd_t.
// Depends on scp_pkg and serial_command_line_parser_macros.svh.
`include "serial_command_line_parser_macros.svh"

module scp_front #(
  parameter int LINE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             rx_byte,
  input  logic signed [scp_pkg::PRESSURE_W-1:0]  present_pressure,
  output logic                                   push,
  output scp_pkg::cmd_t                          push_cmd,
  input  logic                                   queue_ready
);

  localparam int FILL_W = $clog2(LINE_DEPTH + 1);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        head [scp_pkg::HEAD_LEN];
  logic [7:0]        ch   [scp_pkg::HEAD_LEN];
  logic              accept;
  logic              is_end;

  logic [1:0]        pos;
  logic              skipping;
  logic              scanning;
  logic              neg;
  logic [7:0]        pc;
  logic [9:0]        acc;
  logic signed [scp_pkg::PRESSURE_W-1:0] value;
  logic [23:0]       head_word;

  assign in_ready = queue_ready;
  assign accept   = in_valid && in_ready;
  assign is_end   = (rx_byte == scp_pkg::END_MARK);
  assign push     = accept && is_end;

  always_comb begin
    fill_next = fill;
    if (accept) begin
      if (is_end) begin
        fill_next = '0;
      end else if (fill < FILL_W'(LINE_DEPTH)) begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // only the first few positions are ever decoded
  always_ff @(posedge clk) begin
    for (int k = 0; k < scp_pkg::HEAD_LEN; k++) begin
      if (accept && !is_end && fill == FILL_W'(k)) begin
        head[k] <= rx_byte;
      end
    end
  end

  // positions not yet filled in this line read as terminators
  always_comb begin
    for (int k = 0; k < scp_pkg::HEAD_LEN; k++) begin
      ch[k] = (fill > FILL_W'(k)) ? head[k] : 8'd0;
    end
  end

  assign head_word = {ch[0], ch[1], ch[2]};

  // atoi over positions 4..6; pos is relative to position 4
  always_comb begin
    pos      = 2'd0;
    skipping = 1'b1;
    scanning = 1'b1;
    neg      = 1'b0;
    pc       = 8'd0;
    acc      = 10'd0;
    for (int k = 0; k < 3; k++) begin
      if (skipping && ch[4+k] != 8'd0 && (ch[4+k] inside {8'd32, [8'd9:8'd13]})) begin
        pos = pos + 2'd1;
      end else begin
        skipping = 1'b0;
      end
    end
    case (pos)
      2'd0:    pc = ch[4];
      2'd1:    pc = ch[5];
      2'd2:    pc = ch[6];
      default: pc = 8'd0;
    endcase
    if (pc == scp_pkg::CHAR_MINUS || pc == scp_pkg::CHAR_PLUS) begin
      neg = (pc == scp_pkg::CHAR_MINUS);
      pos = pos + 2'd1;
    end
    for (int k = 0; k < 3; k++) begin
      if (scanning && pos <= 2'(k)) begin
        if (ch[4+k] inside {[scp_pkg::CHAR_ZERO:scp_pkg::CHAR_NINE]}) begin
          acc = 10'((acc << 3) + (acc << 1)) + 10'(ch[4+k] - scp_pkg::CHAR_ZERO);
        end else begin
          scanning = 1'b0;
        end
      end
    end
    value = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  end

  always_comb begin
    push_cmd.value    = value;
    push_cmd.pressure = present_pressure;
    if (head_word == scp_pkg::WORD_SET) begin
      push_cmd.reply = scp_pkg::REPLY_SET;
    end else if (head_word == scp_pkg::WORD_STP) begin
      push_cmd.reply = scp_pkg::REPLY_STOP;
    end else if (head_word == scp_pkg::WORD_RUN) begin
      push_cmd.reply = scp_pkg::REPLY_RUN;
    end else if (head_word == scp_pkg::WORD_NOW) begin
      push_cmd.reply = scp_pkg::REPLY_NOW;
    end else begin
      push_cmd.reply = scp_pkg::REPLY_BAD;
    end
  end

  `SCP_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= FILL_W'(LINE_DEPTH))
  `SCP_ASSERT_NEXT(a_fill_clear, clk, rst, push, fill == '0)

endmodule

// File: sv/scp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded commands between front and back.
// Depends on scp_pkg and serial_command_line_parser_macros.svh.
`include "serial_command_line_parser_macros.svh"

module scp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scp_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output scp_pkg::cmd_t pop_cmd
);

  scp_pkg::cmd_t                  entry [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [scp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [scp_pkg::QCNT_W-1:0]     count;
  logic [scp_pkg::QCNT_W-1:0]     count_next;

  assign push_ready = (count < scp_pkg::QCNT_W'(scp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  `SCP_ASSERT_IMPLIES(a_no_overflow, clk, rst, push,
                      count < scp_pkg::QCNT_W'(scp_pkg::QUEUE_DEPTH))
  `SCP_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, count != '0)

endmodule

// File: sv/scp_back.sv
`timescale 1ns / 1ps
// Back end: applies decoded commands to setpoint and run flag, holds the result word.
// Depends on scp_pkg and serial_command_line_parser_macros.svh.
`include "serial_command_line_parser_macros.svh"

module scp_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  scp_pkg::cmd_t                          q_cmd,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             reply,
  output logic signed [scp_pkg::PRESSURE_W-1:0]  setpoint,
  output logic                                   fan_running,
  output logic signed [scp_pkg::PRESSURE_W-1:0]  pressure_report
);

  logic signed [scp_pkg::PRESSURE_W-1:0] set_state;
  logic signed [scp_pkg::PRESSURE_W-1:0] set_state_next;
  logic                                  run_state;
  logic                                  run_state_next;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    set_state_next = set_state;
    run_state_next = run_state;
    case (q_cmd.reply)
      scp_pkg::REPLY_SET:  set_state_next = q_cmd.value;
      scp_pkg::REPLY_STOP: run_state_next = 1'b0;
      scp_pkg::REPLY_RUN:  run_state_next = 1'b1;
      default:             run_state_next = run_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_state <= '0;
      run_state <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        set_state <= set_state_next;
        run_state <= run_state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reply           <= q_cmd.reply;
      setpoint        <= set_state_next;
      fan_running     <= run_state_next;
      pressure_report <= (q_cmd.reply == scp_pkg::REPLY_NOW) ? q_cmd.pressure : '0;
    end
  end

  `SCP_ASSERT_NEXT(a_pop_shows, clk, rst, pop, out_valid)
  `SCP_ASSERT_NEXT(a_run_sets, clk, rst, pop && q_cmd.reply == scp_pkg::REPLY_RUN,
                   fan_running && run_state)
  `SCP_ASSERT_IMPLIES(a_report_zero, clk, rst,
                      out_valid && reply != scp_pkg::REPLY_NOW, pressure_report == '0)

endmodule

// File: sv/serial_command_line_parser.sv
`timescale 1ns / 1ps
// Serial command line parser: one received byte per cycle while the command queue has room, one reply word per ';'.
// Result path: the decoded ';' line is registered in the command queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; the two-entry command queue decouples decode from output.
// Reset (synchronous): clears fill count, setpoint, run flag, queue and output valid;
// line characters are not reset and are only read once written in the current line.
// Depends on scp_pkg, scp_front, scp_queue, scp_back.
module serial_command_line_parser #(
  parameter int LINE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             rx_byte,
  input  logic signed [scp_pkg::PRESSURE_W-1:0]  present_pressure,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             reply,
  output logic signed [scp_pkg::PRESSURE_W-1:0]  setpoint,
  output logic                                   fan_running,
  output logic signed [scp_pkg::PRESSURE_W-1:0]  pressure_report
);

  logic          push;
  logic          push_ready;
  scp_pkg::cmd_t push_cmd;
  logic          pop;
  logic          q_valid;
  scp_pkg::cmd_t q_cmd;

  scp_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .present_pressure (present_pressure),
    .push             (push),
    .push_cmd         (push_cmd),
    .queue_ready      (push_ready)
  );

  scp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  scp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .reply           (reply),
    .setpoint        (setpoint),
    .fan_running     (fan_running),
    .pressure_report (pressure_report)
  );

endmodule

// File: test/command_reply_checker.sv
`timescale 1ns / 1ps
// Watches the byte and reply channels of the command line parser, predicts each reply
// word and compares it field by field. Depends on scp_pkg.
module command_reply_checker #(
  parameter int LINE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [7:0]                             rx_byte,
  input  logic signed [scp_pkg::PRESSURE_W-1:0]  present_pressure,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [2:0]                             reply,
  input  logic signed [scp_pkg::PRESSURE_W-1:0]  setpoint,
  input  logic                                   fan_running,
  input  logic signed [scp_pkg::PRESSURE_W-1:0]  pressure_report,
  output int                                     fail_count,
  output int                                     pending
);

  localparam int PRESSURE_W = scp_pkg::PRESSURE_W;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam int unsigned ARG_FIRST = 4;

  typedef struct packed {
    scp_pkg::reply_t              reply;
    logic signed [PRESSURE_W-1:0] setpoint;
    logic                         fan_running;
    logic signed [PRESSURE_W-1:0] report;
  } command_reply_t;

  command_reply_t replies_due[$];
  logic [7:0] line_chars[LINE_DEPTH];
  int unsigned line_fill;
  logic signed [PRESSURE_W-1:0] held_setpoint;
  logic fan_on;

  // anything at or past the fill point reads as a terminator
  function automatic logic [7:0] char_at(input int unsigned pos);
    if (pos >= line_fill) return 8'd0;
    return line_chars[pos];
  endfunction

  function automatic bit head_matches(input logic [23:0] word);
    logic [7:0] c;
    for (int k = 0; k < 3; k++) begin
      c = char_at(k);
      if (c == 8'd0 || c != word[8*(2-k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // atoi restricted to the three-character argument window
  function automatic logic signed [PRESSURE_W-1:0] window_value();
    int unsigned pos;
    int acc;
    bit neg;
    logic [7:0] c;
    pos = ARG_FIRST;
    acc = 0;
    neg = 1'b0;
    while (pos < scp_pkg::HEAD_LEN && char_at(pos) != 8'd0 && is_blank(char_at(pos))) pos++;
    if (pos < scp_pkg::HEAD_LEN) begin
      c = char_at(pos);
      if (c == scp_pkg::CHAR_MINUS || c == scp_pkg::CHAR_PLUS) begin
        neg = (c == scp_pkg::CHAR_MINUS);
        pos++;
      end
    end
    while (pos < scp_pkg::HEAD_LEN) begin
      c = char_at(pos);
      if (c < scp_pkg::CHAR_ZERO || c > scp_pkg::CHAR_NINE) break;
      acc = acc * 10 + int'(c - scp_pkg::CHAR_ZERO);
      pos++;
    end
    return PRESSURE_W'(neg ? -acc : acc);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    command_reply_t want;
    logic signed [PRESSURE_W-1:0] report_val;
    scp_pkg::reply_t code;
    if (rst) begin
      replies_due.delete();
      line_fill = 0;
      held_setpoint = '0;
      fan_on = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply word", reply, -1);
        end else begin
          want = replies_due.pop_front();
          if (reply !== want.reply) report_mismatch("reply", reply, want.reply);
          if (setpoint !== want.setpoint)
            report_mismatch("setpoint", setpoint, want.setpoint);
          if (fan_running !== want.fan_running)
            report_mismatch("fan_running", fan_running, want.fan_running);
          if (pressure_report !== want.report)
            report_mismatch("pressure_report", pressure_report, want.report);
        end
      end
      if (in_valid && in_ready) begin
        if (rx_byte != scp_pkg::END_MARK) begin
          // overflow bytes are dropped, fill saturates
          if (line_fill < LINE_DEPTH) begin
            line_chars[line_fill] = rx_byte;
            line_fill++;
          end
        end else begin
          report_val = '0;
          if (head_matches(scp_pkg::WORD_SET)) begin
            held_setpoint = window_value();
            code = scp_pkg::REPLY_SET;
          end else if (head_matches(scp_pkg::WORD_STP)) begin
            fan_on = 1'b0;
            code = scp_pkg::REPLY_STOP;
          end else if (head_matches(scp_pkg::WORD_RUN)) begin
            fan_on = 1'b1;
            code = scp_pkg::REPLY_RUN;
          end else if (head_matches(scp_pkg::WORD_NOW)) begin
            report_val = present_pressure;
            code = scp_pkg::REPLY_NOW;
          end else begin
            code = scp_pkg::REPLY_BAD;
          end
          line_fill = 0;
          replies_due.push_back('{code, held_setpoint, fan_on, report_val});
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the command line parser bench: clock, reset, byte stimulus, reply-side stalls
// and the verdict. Depends on scp_pkg, serial_command_line_parser, command_reply_checker.
module tb_top;

  localparam int PRESSURE_W   = scp_pkg::PRESSURE_W;
  localparam int LINE_DEPTH   = 16;
  localparam int RANDOM_WORDS = 2000;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int P_MIN        = -99;
  localparam int P_MAX        = 999;
  localparam int ANY_PRESSURE = -1000;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic signed [PRESSURE_W-1:0] present_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] reply;
  logic signed [PRESSURE_W-1:0] setpoint;
  logic fan_running;
  logic signed [PRESSURE_W-1:0] pressure_report;
  int fail_count;
  int pending;

  logic [7:0] line_buf[$];
  int burst_left = 0;
  int words_sent = 0;
  bit hold_for_replies = 1'b0;
  int directed_words;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  serial_command_line_parser #(.LINE_DEPTH(LINE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .present_pressure(present_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply(reply), .setpoint(setpoint), .fan_running(fan_running),
    .pressure_report(pressure_report)
  );

  command_reply_checker #(.LINE_DEPTH(LINE_DEPTH)) reply_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .present_pressure(present_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply(reply), .setpoint(setpoint), .fan_running(fan_running),
    .pressure_report(pressure_report),
    .fail_count(fail_count), .pending(pending)
  );

  // reply side: out_ready follows a stall mode that is redrawn at random during the run
  always @(posedge clk) begin
    int stall_mode;
    if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count % 5 != 0);
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // one word on the byte channel; gaps and hold-offs only between words
  task automatic send_word(input logic [7:0] b, input logic signed [PRESSURE_W-1:0] p);
    int gap;
    if (hold_for_replies || burst_left == 0) begin
      in_valid <= 1'b0;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      if (hold_for_replies) begin
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        hold_for_replies = 1'b0;
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    present_pressure <= p;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // drains line_buf; end_pressure fixes the pressure on ';' words unless ANY_PRESSURE
  task automatic send_buffer(input int end_pressure);
    logic [7:0] b;
    int p;
    while (line_buf.size() != 0) begin
      b = line_buf.pop_front();
      if (b == scp_pkg::END_MARK && end_pressure != ANY_PRESSURE) p = end_pressure;
      else p = int'($urandom_range(0, P_MAX - P_MIN)) + P_MIN;
      send_word(b, PRESSURE_W'(p));
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_word(input logic [23:0] w);
    line_buf.push_back(w[23:16]);
    line_buf.push_back(w[15:8]);
    line_buf.push_back(w[7:0]);
  endtask

  function automatic logic [7:0] pick_blank();
    logic [7:0] c;
    c = 8'($urandom_range(CHAR_TAB, CHAR_CR + 1));
    return (c == CHAR_CR + 1) ? CHAR_SPACE : c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return scp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic build_random_line();
    int kind;
    int n;
    logic [23:0] word;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0:       word = scp_pkg::WORD_STP;
      1:       word = scp_pkg::WORD_RUN;
      2:       word = scp_pkg::WORD_NOW;
      default: word = scp_pkg::WORD_SET;
    endcase
    if (kind < 8) word ^= 24'd1 << $urandom_range(0, 23);  // near miss
    if (kind < 72) begin
      add_word(word);
      if (word == scp_pkg::WORD_SET || $urandom_range(0, 3) == 0) begin
        line_buf.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(32, 126)) : CHAR_SPACE);
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        case ($urandom_range(0, 3))
          0: line_buf.push_back(scp_pkg::CHAR_MINUS);
          1: line_buf.push_back(scp_pkg::CHAR_PLUS);
          default: ;
        endcase
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_digit());
        if ($urandom_range(0, 4) == 0) line_buf.push_back(8'($urandom_range(32, 126)));
      end
    end else if (kind < 80) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) line_buf.push_back(word[23 - 8*i -: 8]);
    end else if (kind < 88) begin
      // runs past the line store
      add_word(word);
      repeat ($urandom_range(10, 24)) line_buf.push_back(8'($urandom_range(60, 126)));
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // zero byte cuts the argument short
      add_word(word);
      line_buf.push_back(CHAR_SPACE);
      line_buf.push_back(pick_digit());
      line_buf.push_back(8'd0);
      line_buf.push_back(pick_digit());
    end
    line_buf.push_back(scp_pkg::END_MARK);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_text(";");            send_buffer(ANY_PRESSURE);
    add_text("set -99;");     send_buffer(ANY_PRESSURE);
    add_text("run;");         send_buffer(ANY_PRESSURE);
    add_text("now;");         send_buffer(P_MIN);
    add_text("now;");         send_buffer(P_MAX);
    add_text("set 999;");     send_buffer(ANY_PRESSURE);
    add_text("stp;");         send_buffer(ANY_PRESSURE);
    add_text("se;");          send_buffer(ANY_PRESSURE);
    add_text("set;");         send_buffer(ANY_PRESSURE);
    add_text("set \t+7;");    send_buffer(ANY_PRESSURE);
    add_text("set 1");
    line_buf.push_back(8'd0);
    add_text("9;");           send_buffer(ANY_PRESSURE);
    add_text("set -;");       send_buffer(ANY_PRESSURE);
    add_text("set 12345;");   send_buffer(ANY_PRESSURE);
    add_text("runXXXXXXXXXXXXXXXXXXXXX;");
    send_buffer(ANY_PRESSURE);
    add_text("xyz;");         send_buffer(ANY_PRESSURE);
    add_text("set x5;");      send_buffer(ANY_PRESSURE);
    line_buf.push_back(8'd255);
    line_buf.push_back(8'd128);
    line_buf.push_back(8'd0);
    add_text(";");            send_buffer(ANY_PRESSURE);
    add_text("now;");         send_buffer(0);

    directed_words = words_sent;
    hold_for_replies = 1'b1;
    while (words_sent < directed_words + RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) hold_for_replies = 1'b1;
      build_random_line();
      send_buffer(ANY_PRESSURE);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
